FILE: rtl/core/assert_macros.svh
// assertion helpers for the port checker
// each macro takes a label, clock, active-low reset, a trigger and a consequence
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequence must hold in the same cycle as the trigger
`define SVD_ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed");

// consequence must hold in the cycle after the trigger
`define SVD_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/svd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_pkg
// Widths, register indexes and shared types of the square voice decay mixer.
// ----------------------------------------------------------------------------
package svd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PERIOD_W   = 24;
    localparam int LEN_W      = 20;
    localparam int AMP_W      = 15;
    localparam int STEP_W     = 24;
    localparam int ENV_W      = 25;
    localparam int ENV_FRAC   = 24;
    localparam int PHASE_W    = 24;
    localparam int CONTRIB_W  = AMP_W + ENV_W - ENV_FRAC;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // remainder unit walks one dividend bit per cycle
    localparam int DIV_STEPS  = PHASE_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [ENV_W-1:0]   ENV_ONE    = ENV_W'(1) << ENV_FRAC;
    localparam logic [PHASE_W:0]   PHASE_STEP = (PHASE_W + 1)'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD    = 8'd0,
        CFG_LENGTH    = 8'd1,
        CFG_AMPLITUDE = 8'd2,
        CFG_ENV_STEP  = 8'd3
    } cfg_reg_e;

    typedef struct packed {
        logic                start;
        logic [PHASE_W:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [PHASE_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/core/svd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_in_if
// Sample request channel into the mixer: note-start flag and buffer sample.
// ----------------------------------------------------------------------------
interface svd_in_if #(
    parameter int SAMPLE_BITS = svd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          new_note;
    logic signed [SAMPLE_BITS-1:0] mix_in;

    modport source (output valid, output new_note, output mix_in, input ready);
    modport sink   (input valid, input new_note, input mix_in, output ready);
endinterface

FILE: rtl/core/svd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_out_if
// Mixed sample channel out of the mixer with activity and clip flags.
// ----------------------------------------------------------------------------
interface svd_out_if #(
    parameter int SAMPLE_BITS = svd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mix_out;
    logic                          note_active;
    logic                          clipped;

    modport source (output valid, output mix_out, output note_active, output clipped,
                    input ready);
    modport sink   (input valid, input mix_out, input note_active, input clipped,
                    output ready);
endinterface

FILE: rtl/core/svd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface svd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [svd_pkg::CFG_IDX_W-1:0]   index;
    logic [svd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/svd_phase_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_phase_div
// Bit-serial remainder unit: folds an advanced phase back below the period
// when a single subtract is not enough.
// ----------------------------------------------------------------------------
module svd_phase_div (
    input  logic              clk,
    input  logic              rst_n,
    input  svd_pkg::div_req_t req,
    output svd_pkg::div_rsp_t rsp
);
    import svd_pkg::*;

    localparam logic [DIV_CNT_W-1:0] STEPS = DIV_CNT_W'(DIV_STEPS);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [PHASE_W:0]     num_reg,   num_next;
    logic [PERIOD_W-1:0]  den_reg,   den_next;
    logic [PHASE_W-1:0]   rem_reg,   rem_next;

    logic [PHASE_W:0]     trial;
    logic [PHASE_W:0]     trial_sub;
    logic                 trial_ge;

    assign trial     = {rem_reg, num_reg[PHASE_W]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            num_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = trial_ge ? trial_sub[PHASE_W-1:0] : trial[PHASE_W-1:0];
            num_next = {num_reg[PHASE_W-1:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // busy stays up through the cycle the remainder is handed over
    assign rsp.busy      = busy_reg | done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/core/square_voice_decay_mixer_unit.sv
`timescale 1ns / 1ps
// throughput: one sample per cycle unless the receiver or the remainder unit stalls;
// the phase, count and envelope update in one pass
// a phase wrap needing more than one subtract of the period (period under one sample,
// or a period shrunk mid-note) holds the input while the serial remainder unit runs
// reset: period, length, amplitude and step clear to 0, count and phase to 0,
// envelope to 1.0, both pipeline registers empty
// ----------------------------------------------------------------------------
// square_voice_decay_mixer_unit
// Adds a decaying square-wave voice into a signed sample stream with saturation.
// ----------------------------------------------------------------------------
module square_voice_decay_mixer_unit #(
    parameter int SAMPLE_BITS = svd_pkg::SAMPLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    svd_in_if.sink     sample_in,
    svd_out_if.source  sample_out,
    svd_cfg_if.sink    cfg
);
    import svd_pkg::*;

    localparam int SUM_W = ((SAMPLE_BITS > CONTRIB_W) ? SAMPLE_BITS : CONTRIB_W) + 2;
    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SMIN = SUM_W'(-(1 << (SAMPLE_BITS - 1)));

    // configuration
    logic [PERIOD_W-1:0] period_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [AMP_W-1:0]    amp_reg;
    logic [STEP_W-1:0]   step_reg;

    // input stage
    logic                          in_valid_reg, in_valid_next;
    logic                          in_new_note_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;

    // result stage
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_active_reg;
    logic                          out_clip_reg;

    // voice state
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [ENV_W-1:0]   env_reg,   env_next;

    logic               advance;
    logic               div_hold;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [LEN_W-1:0]           cur_count;
    logic [PHASE_W-1:0]         cur_phase;
    logic [ENV_W-1:0]           cur_env;
    logic                       active;
    logic                       positive;
    logic [AMP_W+ENV_W-1:0]     product;
    logic [CONTRIB_W-1:0]       contrib;
    logic signed [SUM_W-1:0]    x_ext;
    logic signed [SUM_W-1:0]    c_ext;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_BITS-1:0] mix_y;
    logic                       clip;
    logic [PHASE_W:0]           phase_inc;
    logic [PHASE_W:0]           period_ext;
    logic [PHASE_W:0]           wrap_diff;
    logic [PHASE_W-1:0]         phase_wrapped;
    logic                       need_div;

    // ------------------------------------------------------------------ config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            length_reg <= '0;
            amp_reg    <= '0;
            step_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PERIOD:    period_reg <= cfg.data[PERIOD_W-1:0];
                CFG_LENGTH:    length_reg <= cfg.data[LEN_W-1:0];
                CFG_AMPLITUDE: amp_reg    <= cfg.data[AMP_W-1:0];
                CFG_ENV_STEP:  step_reg   <= cfg.data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------ handshake
    assign div_hold        = div_rsp.busy;
    assign advance         = in_valid_reg && (!out_valid_reg || sample_out.ready) && !div_hold;
    assign sample_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample_in.ready)
        begin
            in_valid_next = sample_in.valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (sample_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------ voice datapath
    // a note start overrides the stored state before this sample is mixed
    assign cur_count = in_new_note_reg ? '0 : count_reg;
    assign cur_phase = in_new_note_reg ? '0 : phase_reg;
    assign cur_env   = in_new_note_reg ? ENV_ONE : env_reg;

    assign active   = (period_reg != '0) && (cur_count < length_reg);
    assign positive = {cur_phase, 1'b0} < {1'b0, period_reg};

    assign product = (AMP_W + ENV_W)'(amp_reg) * (AMP_W + ENV_W)'(cur_env);
    assign contrib = product[AMP_W+ENV_W-1:ENV_FRAC];

    assign x_ext = SUM_W'(in_sample_reg);
    assign c_ext = $signed({{(SUM_W - CONTRIB_W){1'b0}}, contrib});
    assign sum   = positive ? (x_ext + c_ext) : (x_ext - c_ext);

    always_comb
    begin
        clip  = 1'b0;
        mix_y = in_sample_reg;
        if (active)
        begin
            if (sum > SMAX)
            begin
                clip  = 1'b1;
                mix_y = SMAX[SAMPLE_BITS-1:0];
            end
            else if (sum < SMIN)
            begin
                clip  = 1'b1;
                mix_y = SMIN[SAMPLE_BITS-1:0];
            end
            else
            begin
                mix_y = sum[SAMPLE_BITS-1:0];
            end
        end
    end

    // phase wraps with one subtract; anything further goes to the remainder unit
    assign phase_inc  = {1'b0, cur_phase} + PHASE_STEP;
    assign period_ext = {1'b0, period_reg};
    assign wrap_diff  = phase_inc - period_ext;

    always_comb
    begin
        need_div      = 1'b0;
        phase_wrapped = phase_inc[PHASE_W-1:0];
        if (phase_inc >= period_ext)
        begin
            phase_wrapped = wrap_diff[PHASE_W-1:0];
            if (wrap_diff >= period_ext)
            begin
                need_div = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        env_next   = env_reg;
        if (advance)
        begin
            count_next = cur_count;
            phase_next = cur_phase;
            env_next   = cur_env;
            if (active)
            begin
                count_next = cur_count + LEN_W'(1);
                env_next   = (cur_env > {1'b0, step_reg}) ? (cur_env - {1'b0, step_reg}) : '0;
                if (!need_div)
                begin
                    phase_next = phase_wrapped;
                end
            end
        end
        else if (div_rsp.busy && !div_req.start)
        begin
            phase_next = div_rsp.remainder;
        end
    end

    assign div_req.start    = advance && active && need_div;
    assign div_req.dividend = phase_inc;
    assign div_req.divisor  = period_reg;

    svd_phase_div u_phase_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= '0;
            env_reg       <= ENV_ONE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            env_reg       <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.ready)
        begin
            in_new_note_reg <= sample_in.new_note;
            in_sample_reg   <= sample_in.mix_in;
        end
        if (advance)
        begin
            out_sample_reg <= mix_y;
            out_active_reg <= active;
            out_clip_reg   <= clip;
        end
    end

    assign sample_out.valid       = out_valid_reg;
    assign sample_out.mix_out     = out_sample_reg;
    assign sample_out.note_active = out_active_reg;
    assign sample_out.clipped     = out_clip_reg;

endmodule

FILE: rtl/core/svd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_checker
// Port-level checks on the mixer result channel and register port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svd_checker #(
    parameter int SAMPLE_BITS = svd_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] mix_out,
    input logic                          note_active,
    input logic                          clipped,
    input logic                          cfg_ready
);
    import svd_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // a stalled result holds
    `SVD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mix_out) && $stable(note_active) && $stable(clipped))

    // a clipped sample sits on a rail and only comes from an active voice
    `SVD_ASSERT_SAME(a_clip_rail, clk, rst_n, out_valid && clipped, note_active && (mix_out == SMAX || mix_out == SMIN))

    // register writes are never back-pressured
    `SVD_ASSERT_NEXT(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind square_voice_decay_mixer_unit svd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_svd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (sample_out.valid),
    .out_ready   (sample_out.ready),
    .mix_out     (sample_out.mix_out),
    .note_active (sample_out.note_active),
    .clipped     (sample_out.clipped),
    .cfg_ready   (cfg.ready)
);

FILE: tb/sv/svd_mix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_mix_checker
// Watches the register, sample and result channels of the square voice mixer,
// predicts every mixed sample from its own copy of the voice state and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module svd_mix_checker #(
    parameter int SAMPLE_BITS = svd_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    svd_in_if    in_ch,
    svd_out_if   out_ch,
    svd_cfg_if   cfg_ch,
    output int   mismatches,
    output int   outstanding
);
    import svd_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mix_out;
        logic                          note_active;
        logic                          clipped;
    } mixed_sample_t;

    // register copies
    logic [PERIOD_W-1:0] period_q8_r;
    logic [LEN_W-1:0]    note_len_r;
    logic [AMP_W-1:0]    amp_r;
    logic [STEP_W-1:0]   env_step_r;

    // voice state
    logic [LEN_W-1:0]    note_count;
    logic [PHASE_W-1:0]  voice_phase;
    logic [ENV_W-1:0]    voice_env;

    mixed_sample_t expected_q[$];
    int            result_idx;

    function automatic mixed_sample_t voice_mix(input logic start,
                                                input logic signed [SAMPLE_BITS-1:0] x);
        mixed_sample_t          r;
        logic [AMP_W+ENV_W-1:0] prod;
        logic [CONTRIB_W-1:0]   contrib;
        logic [PHASE_W:0]       phase_next;
        logic                   positive;
        int                     xs;
        int                     cs;
        int                     sum;
        int                     sat_hi;
        int                     sat_lo;
        sat_hi = (1 << (SAMPLE_BITS - 1)) - 1;
        sat_lo = -sat_hi - 1;
        if (start)
        begin
            note_count  = '0;
            voice_phase = '0;
            voice_env   = ENV_ONE;
        end
        r.note_active = (period_q8_r != '0) && (note_count < note_len_r);
        r.clipped     = 1'b0;
        r.mix_out     = x;
        if (r.note_active)
        begin
            prod     = amp_r * voice_env;
            contrib  = prod[AMP_W+ENV_W-1:ENV_FRAC];
            positive = ({1'b0, voice_phase} << 1) < {1'b0, period_q8_r};
            xs       = x;
            cs       = contrib;
            sum      = positive ? xs + cs : xs - cs;
            if (sum > sat_hi)
            begin
                sum       = sat_hi;
                r.clipped = 1'b1;
            end
            else if (sum < sat_lo)
            begin
                sum       = sat_lo;
                r.clipped = 1'b1;
            end
            r.mix_out = sum[SAMPLE_BITS-1:0];

            note_count  = note_count + 1'b1;
            phase_next  = {1'b0, voice_phase} + PHASE_STEP;
            // plain remainder also folds a phase left above a shrunk period
            voice_phase = PHASE_W'(phase_next % {1'b0, period_q8_r});
            voice_env   = (voice_env > {1'b0, env_step_r}) ?
                          voice_env - {1'b0, env_step_r} : '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $realtime, result_idx, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mixed_sample_t want;
        if (!rst_n)
        begin
            period_q8_r = '0;
            note_len_r  = '0;
            amp_r       = '0;
            env_step_r  = '0;
            note_count  = '0;
            voice_phase = '0;
            voice_env   = ENV_ONE;
            expected_q.delete();
            result_idx  = 0;
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_PERIOD:    period_q8_r = cfg_ch.data[PERIOD_W-1:0];
                    CFG_LENGTH:    note_len_r  = cfg_ch.data[LEN_W-1:0];
                    CFG_AMPLITUDE: amp_r       = cfg_ch.data[AMP_W-1:0];
                    CFG_ENV_STEP:  env_step_r  = cfg_ch.data[STEP_W-1:0];
                    default:       ;
                endcase
            end

            // results belong to earlier requests, so pop before pushing
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with no request pending, mix_out",
                                    int'(out_ch.mix_out), 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.mix_out !== want.mix_out)
                        report_mismatch("mix_out", int'(out_ch.mix_out),
                                        int'(want.mix_out));
                    if (out_ch.note_active !== want.note_active)
                        report_mismatch("note_active", int'(out_ch.note_active),
                                        int'(want.note_active));
                    if (out_ch.clipped !== want.clipped)
                        report_mismatch("clipped", int'(out_ch.clipped),
                                        int'(want.clipped));
                end
                result_idx++;
            end

            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(voice_mix(in_ch.new_note, in_ch.mix_in));

            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives note starts and buffer samples into the square voice mixer under a
// range of voice settings, with bursty requests and a stalling receiver, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import svd_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 40;
    // 0.6 in Q0.24, divided by the note length so the envelope falls by 0.6 over the note
    localparam int ENV_DECAY_FULL = 10066330;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TOP = '1;

    typedef enum int {RX_STEADY, RX_COIN, RX_BURSTY} rx_mode_e;

    logic clk;
    logic rst_n;

    svd_in_if  #(.SAMPLE_BITS(SB)) sample_in ();
    svd_out_if #(.SAMPLE_BITS(SB)) sample_out ();
    svd_cfg_if                     cfg ();

    int mismatches;
    int outstanding;
    int burst_left;
    int idle_cycles;

    square_voice_decay_mixer_unit #(.SAMPLE_BITS(SB)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .cfg        (cfg)
    );

    svd_mix_checker #(.SAMPLE_BITS(SB)) mix_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (sample_in),
        .out_ch      (sample_out),
        .cfg_ch      (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // called at a rising edge; returns at the edge that accepts the request
    task automatic push_sample(input logic nn, input logic signed [SB-1:0] x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                sample_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_in.valid    <= 1'b1;
        sample_in.new_note <= nn;
        sample_in.mix_in   <= x;
        do @(posedge clk); while (!sample_in.ready);
    endtask

    task automatic drain_results();
        sample_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] word);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= word;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic apply_voice(input logic [CFG_DATA_W-1:0] period,
                               input logic [CFG_DATA_W-1:0] len_word,
                               input logic [CFG_DATA_W-1:0] amp_word,
                               input logic [CFG_DATA_W-1:0] step);
        cfg_reg_e              regs [4];
        logic [CFG_DATA_W-1:0] words [4];
        int                    first;
        int                    k;
        regs  = '{CFG_PERIOD, CFG_LENGTH, CFG_AMPLITUDE, CFG_ENV_STEP};
        words = '{period, len_word, amp_word, step};
        first = $urandom_range(0, 3);
        drain_results();
        for (k = 0; k < 4; k++)
            write_reg(regs[(first + k) % 4], words[(first + k) % 4]);
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ENV_STEP) + 1, int'(CFG_SPARE_TOP))),
                      CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [SB-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return {1'b0, {(SB-1){1'b1}}};
        if (r == 1)
            return {1'b1, {(SB-1){1'b0}}};
        return SB'($urandom);
    endfunction

    // receiver: steady, coin-flip and bursty stall stretches
    initial
    begin
        rx_mode_e mode;
        int       mode_left;
        int       stall_left;
        mode       = RX_STEADY;
        mode_left  = 0;
        stall_left = 0;
        sample_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                RX_STEADY: sample_out.ready <= 1'b1;
                RX_COIN:   sample_out.ready <= ($urandom_range(0, 1) == 1);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        sample_out.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left = $urandom_range(1, 12);
                        sample_out.ready <= 1'b0;
                    end
                    else
                        sample_out.ready <= 1'b1;
                end
            endcase
        end
    end

    // watchdog on cycles with no request moving on any channel
    always @(posedge clk)
    begin
        if ((sample_in.valid && sample_in.ready) || (sample_out.valid && sample_out.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                   items;
        int                   nseq;
        int                   s;
        int                   n;
        int                   seq_len;
        int                   r;
        logic                 resting;
        logic                 fresh;
        logic [PERIOD_W-1:0]  period_v;
        logic [LEN_W-1:0]     len_v;
        logic [AMP_W-1:0]     amp_v;
        logic [STEP_W-1:0]    step_v;

        idle_cycles = 0;
        burst_left  = 0;
        rst_n <= 1'b0;
        sample_in.valid    <= 1'b0;
        sample_in.new_note <= 1'b0;
        sample_in.mix_in   <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unused register index must be ignored
        write_reg(CFG_SPARE_TOP, '1);
        cfg.valid <= 1'b0;

        // rest after reset: samples pass through
        push_sample(1'b1, 16'sh7FFF);
        push_sample(1'b0, -16'sd32768);

        // four-sample period, six-sample note, full amplitude; clips both ways
        apply_voice(24'd1024, 24'd6, 24'd32767, 24'h19999A);
        push_sample(1'b1, 16'sh7FFF);
        push_sample(1'b0, -16'sd32768);
        push_sample(1'b0, -16'sd32768);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sd12345);
        push_sample(1'b0, -16'sd1);
        push_sample(1'b0, 16'sd100);
        push_sample(1'b0, -16'sd5);

        // period under one sample, envelope clamps to zero on the second step
        apply_voice(24'd255, 24'hFFFFFF, 24'hFF8001, 24'hFFFFFF);
        push_sample(1'b1, 16'sd0);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sh7FFF);

        // longest period, then shrink it mid-note below the running phase
        apply_voice(24'hFFFFFF, 24'hFFFFF, 24'd32767, 24'd0);
        push_sample(1'b1, -16'sd32768);
        push_sample(1'b0, 16'sh7FFF);
        push_sample(1'b0, 16'sd1);
        push_sample(1'b0, -16'sd2);
        apply_voice(24'd600, 24'hFFFFF, 24'd32767, 24'd0);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sd0);

        // shortest nonzero period
        apply_voice(24'd1, 24'd3, 24'd32767, 24'd1);
        push_sample(1'b1, 16'sd0);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sd0);

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                period_v = '0;
            else if (r == 1)
                period_v = PERIOD_W'($urandom_range(1, 511));
            else if (r == 2)
                period_v = ($urandom_range(0, 1) == 1) ? '1 : PERIOD_W'($urandom);
            else
                period_v = PERIOD_W'($urandom_range(512, 8192));

            r = $urandom_range(0, 9);
            if (r == 0)
                len_v = '0;
            else if (r == 1)
                len_v = '1;
            else
                len_v = LEN_W'($urandom_range(1, 100));

            r = $urandom_range(0, 7);
            if (r == 0)
                amp_v = '0;
            else if (r == 1)
                amp_v = '1;
            else
                amp_v = AMP_W'($urandom);

            r = $urandom_range(0, 7);
            if (r == 0)
                step_v = '0;
            else if (r == 1)
                step_v = '1;
            else if (r == 2)
                step_v = STEP_W'($urandom);
            else
                step_v = STEP_W'(ENV_DECAY_FULL / ((len_v == '0) ? 1 : int'(len_v)));

            // junk above the register widths must be dropped
            apply_voice(period_v,
                        {CFG_DATA_W'($urandom) & ~CFG_DATA_W'({LEN_W{1'b1}})} | len_v,
                        {CFG_DATA_W'($urandom) & ~CFG_DATA_W'({AMP_W{1'b1}})} | amp_v,
                        step_v);

            resting = (period_v == '0) || (len_v == '0);
            nseq    = $urandom_range(1, 4);
            for (s = 0; s < nseq; s++)
            begin
                // sometimes carry the running note across the register change
                fresh = !(s == 0 && $urandom_range(0, 3) == 0);
                if (resting)
                    seq_len = $urandom_range(1, 8);
                else if (len_v > LEN_W'(100))
                    seq_len = $urandom_range(1, 60);
                else
                    seq_len = $urandom_range(1, int'(len_v) + 8);
                for (n = 0; n < seq_len; n++)
                begin
                    push_sample((n == 0) ? fresh : ($urandom_range(0, 49) == 0),
                                pick_sample());
                    items++;
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/svd_pkg.sv
rtl/core/svd_in_if.sv
rtl/core/svd_out_if.sv
rtl/core/svd_cfg_if.sv
rtl/core/svd_phase_div.sv
rtl/core/square_voice_decay_mixer_unit.sv
rtl/core/svd_checker.sv
tb/sv/svd_mix_checker.sv
tb/sv/testbench.sv
